FILE: rtl/sigma_delta_dop_packer_defines.svh
// Assertion macros shared by the DoP packer checker.
`ifndef SIGMA_DELTA_DOP_PACKER_DEFINES_SVH
`define SIGMA_DELTA_DOP_PACKER_DEFINES_SVH

// Same-cycle implication, held off while reset is low.
`define SDP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is low.
`define SDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sdp_pkg.sv
// Shared constants and types of the sigma-delta DoP packer.
`timescale 1ns / 1ps
package sdp_pkg;

  // Stream field widths
  localparam int unsigned IN_W        = 24;
  localparam int unsigned OUT_W       = 24;
  localparam int unsigned TDATA_IN_W  = 2 * IN_W;
  localparam int unsigned TDATA_OUT_W = 2 * OUT_W;

  // Modulator framing
  localparam int unsigned BITS_PER_FRAME = 16;
  localparam int unsigned BIT_CNT_W      = $clog2(BITS_PER_FRAME);
  localparam int unsigned STAGES         = 4;
  localparam int unsigned STAGE_W        = $clog2(STAGES);

  // Defaults for the top-level parameters
  localparam int unsigned SAMPLE_WIDTH_DEF = 24;
  localparam int unsigned INTEG_WIDTH_DEF  = 32;
  localparam int unsigned QUEUE_DEPTH      = 2;

  // DoP marker bytes
  localparam logic [7:0] MARKER_EVEN = 8'h05;
  localparam logic [7:0] MARKER_ODD  = 8'hFA;

  // One queued frame: samples already sign-extended, plus its marker phase
  typedef struct packed {
    logic                   phase;
    logic signed [IN_W-1:0] right;
    logic signed [IN_W-1:0] left;
  } frame_t;

  // Sequencer to channel datapath
  typedef struct packed {
    logic               step;
    logic [STAGE_W-1:0] stage;
  } chan_ctrl_t;

endpackage

FILE: rtl/sdp_front.sv
// Input side: takes stereo frames, sign-extends, tags the marker phase, queues them.
`timescale 1ns / 1ps
module sdp_front #(
  parameter int unsigned SAMPLE_WIDTH = sdp_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned DEPTH        = sdp_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sdp_pkg::TDATA_IN_W-1:0] in_data_i,
  output logic                          q_valid_o,
  input  logic                          q_ready_i,
  output sdp_pkg::frame_t               q_entry_o
);
  import sdp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SHIFT = IN_W - SAMPLE_WIDTH;

  frame_t               mem_q [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]     count_q;
  logic                 phase_q;
  logic [IN_W-1:0]      left_shift, right_shift;
  logic signed [IN_W-1:0] left_ext, right_ext;
  frame_t               entry_d;
  logic                 push, pop;

  // Keep the low SAMPLE_WIDTH bits and sign-extend from the top one
  always_comb begin
    left_shift  = in_data_i[IN_W-1:0] << SHIFT;
    right_shift = in_data_i[2*IN_W-1:IN_W] << SHIFT;
    left_ext    = $signed(left_shift) >>> SHIFT;
    right_ext   = $signed(right_shift) >>> SHIFT;
    entry_d.left  = left_ext;
    entry_d.right = right_ext;
    entry_d.phase = phase_q;
  end

  assign in_ready_o = (count_q != CNT_W'(DEPTH));
  assign q_valid_o  = (count_q != '0);
  assign push       = in_valid_i & in_ready_o;
  assign pop        = q_valid_o & q_ready_i;
  assign q_entry_o  = mem_q[rd_ptr_q];

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry_d;
    end
  end

  // Pointers, fill count and marker phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      phase_q  <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
        phase_q  <= ~phase_q;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/sdp_chan.sv
// One channel of the fourth-order loop: a single saturating adder stepped over the stages.
`timescale 1ns / 1ps
module sdp_chan #(
  parameter int unsigned SAMPLE_WIDTH = sdp_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned INTEG_WIDTH  = sdp_pkg::INTEG_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sdp_pkg::chan_ctrl_t           ctrl_i,
  input  logic signed [sdp_pkg::IN_W-1:0] sample_i,
  output logic                          bit_o,
  output logic                          clip_o
);
  import sdp_pkg::*;

  localparam int unsigned SUM_W = INTEG_WIDTH + 2;
  localparam logic signed [SUM_W-1:0] FULL_SCALE = SUM_W'(1) << (SAMPLE_WIDTH - 1);
  localparam logic [INTEG_WIDTH-1:0] SAT_MAX = {1'b0, {(INTEG_WIDTH-1){1'b1}}};
  localparam logic [INTEG_WIDTH-1:0] SAT_MIN = {1'b1, {(INTEG_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    FB_NONE = 2'd0,
    FB_POS  = 2'd1,
    FB_NEG  = 2'd2
  } fb_e;

  logic [INTEG_WIDTH-1:0] integ_q [STAGES];
  logic [INTEG_WIDTH-1:0] prev_q;
  fb_e                    fb_q;
  logic [INTEG_WIDTH-1:0] cur;
  logic signed [SUM_W-1:0] acc, addend, fbv, sum;
  logic [INTEG_WIDTH-1:0] sat;
  logic                   ovf, dec;

  // Integrator update: stage 0 takes the sample, later stages the stage before
  always_comb begin
    cur    = integ_q[ctrl_i.stage];
    acc    = {{2{cur[INTEG_WIDTH-1]}}, cur};
    if (ctrl_i.stage == STAGE_W'(0)) begin
      addend = {{(SUM_W-IN_W){sample_i[IN_W-1]}}, sample_i};
    end else begin
      addend = {{2{prev_q[INTEG_WIDTH-1]}}, prev_q};
    end
    case (fb_q)
      FB_POS:  fbv = FULL_SCALE;
      FB_NEG:  fbv = -FULL_SCALE;
      default: fbv = '0;
    endcase
    sum = acc + addend - fbv;
    // Top three bits disagree: result left the integrator range
    ovf = ~((&sum[SUM_W-1:INTEG_WIDTH-1]) | ~(|sum[SUM_W-1:INTEG_WIDTH-1]));
    if (ovf) begin
      sat = sum[SUM_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      sat = sum[INTEG_WIDTH-1:0];
    end
    dec = ~sat[INTEG_WIDTH-1];
  end

  assign bit_o  = dec;
  assign clip_o = ctrl_i.step & ovf;

  // Integrator state and quantiser feedback
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STAGES; k++) begin
        integ_q[k] <= '0;
      end
      prev_q <= '0;
      fb_q   <= FB_NONE;
    end else if (ctrl_i.step) begin
      integ_q[ctrl_i.stage] <= sat;
      prev_q                <= sat;
      if (ctrl_i.stage == STAGE_W'(STAGES - 1)) begin
        fb_q <= dec ? FB_POS : FB_NEG;
      end
    end
  end

endmodule

FILE: rtl/sdp_back.sv
// Back end: sequences both channel loops over a frame and holds the packed DoP result.
`timescale 1ns / 1ps
module sdp_back #(
  parameter int unsigned SAMPLE_WIDTH = sdp_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned INTEG_WIDTH  = sdp_pkg::INTEG_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  output logic                            q_ready_o,
  input  sdp_pkg::frame_t                 q_entry_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sdp_pkg::TDATA_OUT_W-1:0] out_data_o,
  output logic                            out_user_o
);
  import sdp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e                   state_q;
  logic [STAGE_W-1:0]       stage_q;
  logic [BIT_CNT_W-1:0]     bit_cnt_q;
  logic [BITS_PER_FRAME-1:0] left_bits_q, right_bits_q;
  logic                     clip_q, phase_q;
  logic signed [IN_W-1:0]   left_q, right_q;
  logic                     out_valid_q, out_user_q;
  logic [TDATA_OUT_W-1:0]   out_data_q;
  chan_ctrl_t               ctrl;
  logic                     left_bit, right_bit, left_clip, right_clip;
  logic                     out_free;
  logic [7:0]               marker;

  assign ctrl.step  = (state_q == ST_RUN);
  assign ctrl.stage = stage_q;
  assign q_ready_o  = (state_q == ST_IDLE);
  assign out_free   = ~out_valid_q | out_ready_i;
  assign marker     = phase_q ? MARKER_ODD : MARKER_EVEN;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  sdp_chan #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .INTEG_WIDTH  (INTEG_WIDTH)
  ) u_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (left_q),
    .bit_o    (left_bit),
    .clip_o   (left_clip)
  );

  sdp_chan #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .INTEG_WIDTH  (INTEG_WIDTH)
  ) u_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (right_q),
    .bit_o    (right_bit),
    .clip_o   (right_clip)
  );

  // Frame sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      stage_q      <= '0;
      bit_cnt_q    <= '0;
      left_bits_q  <= '0;
      right_bits_q <= '0;
      clip_q       <= 1'b0;
      phase_q      <= 1'b0;
      left_q       <= '0;
      right_q      <= '0;
      out_valid_q  <= 1'b0;
      out_user_q   <= 1'b0;
      out_data_q   <= '0;
    end else begin
      // In ST_DONE the result slot is refilled below instead
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            left_q    <= q_entry_i.left;
            right_q   <= q_entry_i.right;
            phase_q   <= q_entry_i.phase;
            clip_q    <= 1'b0;
            stage_q   <= '0;
            bit_cnt_q <= '0;
            state_q   <= ST_RUN;
          end
        end
        ST_RUN: begin
          clip_q <= clip_q | left_clip | right_clip;
          if (stage_q == STAGE_W'(STAGES - 1)) begin
            stage_q      <= '0;
            left_bits_q  <= {left_bits_q[BITS_PER_FRAME-2:0], left_bit};
            right_bits_q <= {right_bits_q[BITS_PER_FRAME-2:0], right_bit};
            bit_cnt_q    <= bit_cnt_q + 1'b1;
            if (bit_cnt_q == BIT_CNT_W'(BITS_PER_FRAME - 1)) begin
              state_q <= ST_DONE;
            end
          end else begin
            stage_q <= stage_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {marker, right_bits_q, marker, left_bits_q};
            out_user_q  <= clip_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/sigma_delta_dop_packer.sv
// Top level of the stereo sigma-delta modulator with DoP packing.
`timescale 1ns / 1ps
// Takes one stereo Q1.23 PCM frame per input transfer and returns one pair of
// 24-bit DoP words (marker 0x05/0xFA alternating per frame, 16 DSD bits, first
// bit in bit 15) plus a clip flag in tuser. In the modulator each channel
// owns one saturating adder that steps through the four integrator stages,
// one stage per clock, for 16 DSD bits. Before that the frame is loaded from
// the queue; after it the result goes to the output register once that is
// free. Both channels run side by side. A two-entry queue at the input lets
// the next frames be taken while one is in work, and the output register
// holds a finished result while the modulator moves on to the next frame.
module sigma_delta_dop_packer #(
  parameter int unsigned SAMPLE_WIDTH = sdp_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned INTEG_WIDTH  = sdp_pkg::INTEG_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // left_sample [23:0], right_sample [47:24]
  input  logic [sdp_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // left_dop_word [23:0], right_dop_word [47:24]
  output logic [sdp_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  // clipped [0]
  output logic                            m_axis_tuser
);
  import sdp_pkg::*;

  logic   q_valid, q_ready;
  frame_t q_entry;

  sdp_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .DEPTH        (QUEUE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_entry_o  (q_entry)
  );

  sdp_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .INTEG_WIDTH  (INTEG_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_entry_i   (q_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

FILE: rtl/sdp_checker.sv
// Port-level checks on the DoP packer, bound to the top level.
`timescale 1ns / 1ps
`include "sigma_delta_dop_packer_defines.svh"
module sdp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sdp_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);
  import sdp_pkg::*;

  // A stalled result holds
  `SDP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // Marker byte is one of the two DoP codes
  `SDP_ASSERT_IMPL(a_marker_code, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[23:16] == MARKER_EVEN || m_axis_tdata[23:16] == MARKER_ODD, "bad DoP marker")

  // Both channels carry the same marker
  `SDP_ASSERT_IMPL(a_marker_shared, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[23:16] == m_axis_tdata[47:40], "channel markers differ")

  // A result straight after a transfer carries the other marker
  `SDP_ASSERT_NEXT(a_marker_toggle, clk_i, rst_ni, m_axis_tvalid && m_axis_tready, !m_axis_tvalid || m_axis_tdata[23:16] != $past(m_axis_tdata[23:16]), "marker did not alternate")

endmodule

bind sigma_delta_dop_packer sdp_checker u_sdp_checker (.*);

FILE: verif/tb_top.sv
// Self-checking testbench for the stereo sigma-delta DoP packer.
`timescale 1ns / 1ps
// A short table of hand-picked frames comes first: reset state, full-scale
// extremes and runs that drive the integrators into saturation. Random runs
// of held, ramped and noisy samples follow. Each accepted frame goes through a
// bit-accurate model of the fourth-order loop, and each result transfer is
// compared field by field with the oldest predicted frame. Both stream sides
// idle at random, and the output side holds off once for a long stretch.
module tb_top;
  import sdp_pkg::*;

  localparam int N_ITEMS   = 1300;
  localparam int HOLD_AT   = 150;
  localparam int HOLD_LEN  = 400;
  localparam int DRAIN_CYC = 200;

  localparam longint FULL_SCALE = longint'(1) << (SAMPLE_WIDTH_DEF - 1);
  localparam longint INTEG_MAX  = (longint'(1) << (INTEG_WIDTH_DEF - 1)) - 1;
  localparam longint INTEG_MIN  = -INTEG_MAX - 1;

  // Feedback held between modulator updates
  typedef enum logic [1:0] {
    FB_ZERO = 2'd0,
    FB_POS  = 2'd1,
    FB_NEG  = 2'd2
  } fb_code_e;

  typedef enum int {
    CH_LEFT  = 0,
    CH_RIGHT = 1
  } chan_e;

  // One predicted result transfer
  typedef struct {
    logic [OUT_W-1:0] left_word;
    logic [OUT_W-1:0] right_word;
    logic             clipped;
  } dop_frame_t;

  // One row of the hand-picked stimulus; marker and first DSD bit are typed in
  // only where they are obvious
  typedef struct packed {
    logic [IN_W-1:0] left;
    logic [IN_W-1:0] right;
    logic            pinned;
    logic [7:0]      marker;
    logic            first_bit;
  } stim_row_t;

  localparam int N_ROWS = 18;
  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{24'h000000, 24'h000000, 1'b1, MARKER_EVEN, 1'b1},  // zero in last stage
    '{24'h000000, 24'h000000, 1'b0, 8'h00, 1'b0},
    '{24'h7FFFFF, 24'h800000, 1'b0, 8'h00, 1'b0},
    '{24'h800000, 24'h7FFFFF, 1'b0, 8'h00, 1'b0},
    '{24'h7FFFFF, 24'h7FFFFF, 1'b0, 8'h00, 1'b0},
    '{24'h7FFFFF, 24'h7FFFFF, 1'b0, 8'h00, 1'b0},
    '{24'h800000, 24'h800000, 1'b0, 8'h00, 1'b0},
    '{24'h800000, 24'h800000, 1'b0, 8'h00, 1'b0},
    '{24'h800000, 24'h800000, 1'b0, 8'h00, 1'b0},
    '{24'h000001, 24'hFFFFFF, 1'b0, 8'h00, 1'b0},
    '{24'hFFFFFF, 24'h000001, 1'b0, 8'h00, 1'b0},
    '{24'h555555, 24'hAAAAAA, 1'b0, 8'h00, 1'b0},
    '{24'hAAAAAA, 24'h555555, 1'b0, 8'h00, 1'b0},
    '{24'h400000, 24'hC00000, 1'b0, 8'h00, 1'b0},
    '{24'h000000, 24'h000000, 1'b0, 8'h00, 1'b0},
    '{24'h123456, 24'hEDCBA9, 1'b0, 8'h00, 1'b0},
    '{24'h7FFFFF, 24'h000000, 1'b0, 8'h00, 1'b0},
    '{24'h000000, 24'h800000, 1'b0, 8'h00, 1'b0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  // Loop state of the model
  longint     integ_state [2][STAGES];
  fb_code_e   fb_state [2];
  bit         marker_odd;

  dop_frame_t dop_expected [$];
  int         frames_sent;
  int         frames_checked;
  int         mismatches;
  bit         tx_calm;
  bit         rx_calm;

  sigma_delta_dop_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Idle cycles before the next transfer; calm stretches keep the bus busy
  function automatic int draw_idle(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 10));
  endfunction

  // Sixteen loop updates of one channel with its sample held
  function automatic logic [BITS_PER_FRAME-1:0] modulate_channel(input chan_e ch,
                                                                 input logic [IN_W-1:0] raw,
                                                                 inout bit clip);
    longint x;
    longint fbv;
    longint acc;
    longint prev;
    int i;
    int k;
    logic [BITS_PER_FRAME-1:0] dsd;
    x = longint'($signed(raw));
    dsd = '0;
    for (i = 0; i < BITS_PER_FRAME; i++) begin
      case (fb_state[ch])
        FB_POS:  fbv = FULL_SCALE;
        FB_NEG:  fbv = -FULL_SCALE;
        default: fbv = 0;
      endcase
      prev = x;
      for (k = 0; k < STAGES; k++) begin
        acc = integ_state[ch][k] + prev - fbv;
        if (acc > INTEG_MAX) begin
          acc = INTEG_MAX;
          clip = 1'b1;
        end else if (acc < INTEG_MIN) begin
          acc = INTEG_MIN;
          clip = 1'b1;
        end
        integ_state[ch][k] = acc;
        prev = acc;
      end
      // zero in the last stage counts as a positive decision
      if (integ_state[ch][STAGES-1] >= 0) begin
        fb_state[ch] = FB_POS;
        dsd = {dsd[BITS_PER_FRAME-2:0], 1'b1};
      end else begin
        fb_state[ch] = FB_NEG;
        dsd = {dsd[BITS_PER_FRAME-2:0], 1'b0};
      end
    end
    return dsd;
  endfunction

  function automatic dop_frame_t predict_dop_frame(input logic [IN_W-1:0] left,
                                                   input logic [IN_W-1:0] right);
    dop_frame_t f;
    bit clip;
    logic [7:0] marker;
    logic [BITS_PER_FRAME-1:0] dsd_l;
    logic [BITS_PER_FRAME-1:0] dsd_r;
    clip = 1'b0;
    dsd_l = modulate_channel(CH_LEFT, left, clip);
    dsd_r = modulate_channel(CH_RIGHT, right, clip);
    marker = marker_odd ? MARKER_ODD : MARKER_EVEN;
    f.left_word = {marker, dsd_l};
    f.right_word = {marker, dsd_r};
    f.clipped = clip;
    marker_odd = !marker_odd;
    return f;
  endfunction

  // Offer one frame, wait for its transfer, then record the prediction
  task automatic send_frame(input logic [IN_W-1:0] left, input logic [IN_W-1:0] right,
                            output dop_frame_t pred);
    int gap;
    gap = draw_idle(tx_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {right, left};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_dop_frame(left, right);
    dop_expected.push_back(pred);
    frames_sent++;
  endtask

  function automatic logic [IN_W-1:0] draw_sample();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return IN_W'(int'($urandom_range(0, 8191)) - 4096);
    if (pick < 65) return IN_W'(int'($urandom_range(0, 2097151)) - 1048576);
    if (pick < 80) begin
      case ($urandom_range(0, 3))
        0:       return 24'h7FFFFF;
        1:       return 24'h800000;
        2:       return 24'h000000;
        default: return 24'hFFFFFF;
      endcase
    end
    return IN_W'($urandom);
  endfunction

  // Output side: random stalls, one long hold-off, field-by-field compare
  initial begin
    dop_frame_t exp_f;
    int stall;
    bit held;
    m_axis_tready <= 1'b0;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && frames_checked == HOLD_AT) begin
        held = 1'b1;
        stall = HOLD_LEN;
      end else begin
        stall = draw_idle(rx_calm);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      frames_checked++;
      if (dop_expected.size() == 0) begin
        report($sformatf("result transfer with nothing expected: %h/%b",
                         m_axis_tdata, m_axis_tuser));
      end else begin
        exp_f = dop_expected.pop_front();
        if (m_axis_tdata[OUT_W-1:0] !== exp_f.left_word)
          report($sformatf("frame %0d left word %h, expected %h", frames_checked,
                           m_axis_tdata[OUT_W-1:0], exp_f.left_word));
        if (m_axis_tdata[2*OUT_W-1:OUT_W] !== exp_f.right_word)
          report($sformatf("frame %0d right word %h, expected %h", frames_checked,
                           m_axis_tdata[2*OUT_W-1:OUT_W], exp_f.right_word));
        if (m_axis_tuser !== exp_f.clipped)
          report($sformatf("frame %0d clip flag %b, expected %b", frames_checked,
                           m_axis_tuser, exp_f.clipped));
      end
    end
  end

  // Input side: table first, then random runs
  initial begin
    dop_frame_t pred;
    logic [IN_W-1:0] base_l;
    logic [IN_W-1:0] base_r;
    logic [IN_W-1:0] step_l;
    logic [IN_W-1:0] step_r;
    logic [IN_W-1:0] l;
    logic [IN_W-1:0] r;
    int run_len;
    int shape;
    int j;
    int n;
    for (j = 0; j < 2; j++) begin
      for (n = 0; n < STAGES; n++) integ_state[j][n] = 0;
      fb_state[j] = FB_ZERO;
    end
    marker_odd = 1'b0;
    frames_sent = 0;
    frames_checked = 0;
    mismatches = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < N_ROWS; n++) begin
      send_frame(DIRECTED_ROWS[n].left, DIRECTED_ROWS[n].right, pred);
      if (DIRECTED_ROWS[n].pinned) begin
        if (pred.left_word[OUT_W-1:BITS_PER_FRAME] !== DIRECTED_ROWS[n].marker ||
            pred.right_word[OUT_W-1:BITS_PER_FRAME] !== DIRECTED_ROWS[n].marker)
          report($sformatf("row %0d marker byte not %h", n, DIRECTED_ROWS[n].marker));
        if (pred.left_word[BITS_PER_FRAME-1] !== DIRECTED_ROWS[n].first_bit)
          report($sformatf("row %0d first DSD bit not %b", n, DIRECTED_ROWS[n].first_bit));
      end
    end

    // Runs of held, ramped and noisy samples, as a PCM stream would carry
    while (frames_sent < N_ITEMS) begin
      run_len = $urandom_range(1, 24);
      shape = $urandom_range(0, 3);
      base_l = draw_sample();
      base_r = draw_sample();
      step_l = IN_W'(int'($urandom_range(0, 65535)) - 32768);
      step_r = IN_W'(int'($urandom_range(0, 65535)) - 32768);
      for (j = 0; j < run_len; j++) begin
        case (shape)
          0: begin
            l = base_l;
            r = base_r;
          end
          1: begin
            l = base_l + IN_W'(j) * step_l;
            r = base_r + IN_W'(j) * step_r;
          end
          2: begin
            l = draw_sample();
            r = draw_sample();
          end
          default: begin
            l = base_l;
            r = draw_sample();
          end
        endcase
        send_frame(l, r, pred);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (dop_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #15ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
